FILE: rtl/core/snfd_pkg.sv
package snfd_pkg;

  localparam logic [7:0]  FOOTER_BYTE  = 8'hF7;
  localparam logic [47:0] HEADER_RESET = 48'hF000_2102_0002;

  localparam logic [3:0] POS_COMMAND  = 4'd6;
  localparam logic [3:0] POS_ARGUMENT = 4'd7;
  localparam logic [3:0] POS_PAIRS    = 4'd8;
  localparam logic [3:0] POS_MIN_LAST = 4'd10;
  localparam logic [3:0] POS_MAX      = 4'd15;

  localparam logic [2:0] HEADER_LAST_IDX = 3'd5;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_LENGTH   = 3'd1;
  localparam logic [2:0] ST_HEADER   = 3'd2;
  localparam logic [2:0] ST_FOOTER   = 3'd3;
  localparam logic [2:0] ST_CHECKSUM = 3'd4;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [2:0] {
    OP_HEADER   = 3'd0,
    OP_COMMAND  = 3'd1,
    OP_ARGUMENT = 3'd2,
    OP_HIGH     = 3'd3,
    OP_LOW      = 3'd4,
    OP_END      = 3'd5
  } op_kind_t;

  // flag: header byte mismatch on OP_HEADER, bad length on OP_END
  typedef struct packed {
    op_kind_t   kind;
    logic [7:0] value;
    logic       flag;
  } op_t;

endpackage

FILE: rtl/core/sysex_nibble_frame_decoder.sv
// channel | handshake            | payload
// --------+----------------------+----------------------------------------------
// in      | in_valid / in_ready  | rx_byte, end_of_message
// out     | out_valid / out_ready| item_kind, data_byte, command_byte,
//         |                      | argument_byte, status
// cfg     | cfg_valid / cfg_ready| header_bytes
//
// One byte per cycle sustained while the queue has room; a result's byte is
// written into a queue slot at the accepting edge, and the back stage then
// loads the output register from the queue head when it pops that entry.
// Synchronous active-high reset clears frame state, the queue and out_valid
// (the output payload registers are not reset), and loads the default header.
// A stalled output backs up the queue; in_ready drops only once it is full.
module sysex_nibble_frame_decoder import snfd_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  input  logic        end_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        item_kind,
  output logic [7:0]  data_byte,
  output logic [7:0]  command_byte,
  output logic [7:0]  argument_byte,
  output logic [2:0]  status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [47:0] header_bytes
);

  logic push;
  op_t  push_op;
  logic queue_full;
  logic pop;
  logic head_valid;
  op_t  head_op;

  snfd_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .rx_byte        (rx_byte),
    .end_of_message (end_of_message),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .header_bytes   (header_bytes),
    .queue_full     (queue_full),
    .push           (push),
    .push_op        (push_op)
  );

  snfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_op    (push_op),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_op    (head_op)
  );

  snfd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (head_valid),
    .head_op       (head_op),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .item_kind     (item_kind),
    .data_byte     (data_byte),
    .command_byte  (command_byte),
    .argument_byte (argument_byte),
    .status        (status)
  );

endmodule

FILE: rtl/core/snfd_front.sv
module snfd_front import snfd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  input  logic        end_of_message,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [47:0] header_bytes,
  input  logic        queue_full,
  output logic        push,
  output op_t         push_op
);

  logic [47:0] header_reg;
  logic [3:0]  pos;
  logic        phase;
  logic [5:0]  shift;
  logic [7:0]  expected;

  assign cfg_ready = 1'b1;
  assign in_ready  = !queue_full;
  assign push      = in_valid && in_ready;

  assign shift    = {HEADER_LAST_IDX - pos[2:0], 3'b000};
  assign expected = 8'(header_reg >> shift);

  always_comb begin
    push_op.value = rx_byte;
    push_op.flag  = 1'b0;
    if (end_of_message) begin
      push_op.kind = OP_END;
      push_op.flag = (pos < POS_MIN_LAST) || phase;
    end else if (pos < POS_COMMAND) begin
      push_op.kind = OP_HEADER;
      push_op.flag = (rx_byte != expected);
    end else if (pos == POS_COMMAND) begin
      push_op.kind = OP_COMMAND;
    end else if (pos == POS_ARGUMENT) begin
      push_op.kind = OP_ARGUMENT;
    end else if (!phase) begin
      push_op.kind = OP_HIGH;
    end else begin
      push_op.kind = OP_LOW;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_reg <= HEADER_RESET;
    end else if (cfg_valid && cfg_ready) begin
      header_reg <= header_bytes;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos   <= '0;
      phase <= 1'b0;
    end else if (push) begin
      if (end_of_message) begin
        pos   <= '0;
        phase <= 1'b0;
      end else begin
        if (pos >= POS_PAIRS) begin
          phase <= !phase;
        end
        if (pos != POS_MAX) begin
          pos <= pos + 4'd1;
        end
      end
    end
  end

endmodule

FILE: rtl/core/snfd_queue.sv
module snfd_queue import snfd_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  op_t  push_op,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output op_t  head_op
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  op_t              slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_FULL);
  assign head_valid = (count != '0);
  assign head_op    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

FILE: rtl/core/snfd_back.sv
module snfd_back import snfd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       head_valid,
  input  op_t        head_op,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       item_kind,
  output logic [7:0] data_byte,
  output logic [7:0] command_byte,
  output logic [7:0] argument_byte,
  output logic [2:0] status
);

  logic       header_match;
  logic [3:0] high_nibble;
  logic [7:0] held_byte;
  logic       held_valid;
  logic [7:0] running_sum;
  logic [7:0] saved_command;
  logic [7:0] saved_argument;

  logic       emit;
  logic [7:0] packed_byte;
  logic [2:0] end_status;

  assign pop         = head_valid && (!out_valid || out_ready);
  assign packed_byte = {high_nibble, 4'b0000} | head_op.value;

  always_comb begin
    priority if (head_op.flag) begin
      end_status = ST_LENGTH;
    end else if (!header_match) begin
      end_status = ST_HEADER;
    end else if (head_op.value != FOOTER_BYTE) begin
      end_status = ST_FOOTER;
    end else if (!held_valid || held_byte != running_sum) begin
      end_status = ST_CHECKSUM;
    end else begin
      end_status = ST_OK;
    end
  end

  always_comb begin
    emit = 1'b0;
    if (pop) begin
      if (head_op.kind == OP_END) begin
        emit = 1'b1;
      end else if (head_op.kind == OP_LOW) begin
        emit = held_valid && header_match;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_match   <= 1'b1;
      high_nibble    <= '0;
      held_byte      <= '0;
      held_valid     <= 1'b0;
      running_sum    <= '0;
      saved_command  <= '0;
      saved_argument <= '0;
    end else if (pop) begin
      unique case (head_op.kind)
        OP_HEADER: begin
          if (head_op.flag) begin
            header_match <= 1'b0;
          end
        end
        OP_COMMAND:  saved_command  <= head_op.value;
        OP_ARGUMENT: saved_argument <= head_op.value;
        OP_HIGH:     high_nibble    <= head_op.value[3:0];
        OP_LOW: begin
          if (held_valid && header_match) begin
            running_sum <= running_sum + held_byte;
          end
          held_byte  <= packed_byte;
          held_valid <= 1'b1;
        end
        OP_END: begin
          header_match   <= 1'b1;
          high_nibble    <= '0;
          held_byte      <= '0;
          held_valid     <= 1'b0;
          running_sum    <= '0;
          saved_command  <= '0;
          saved_argument <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      if (head_op.kind == OP_END) begin
        item_kind     <= KIND_STATUS;
        data_byte     <= '0;
        command_byte  <= saved_command;
        argument_byte <= saved_argument;
        status        <= end_status;
      end else begin
        item_kind     <= KIND_DATA;
        data_byte     <= held_byte;
        command_byte  <= '0;
        argument_byte <= '0;
        status        <= ST_OK;
      end
    end
  end

endmodule

FILE: test/sysex_nibble_frame_decoder_tb.sv
`timescale 1ns / 1ps

module sysex_nibble_frame_decoder_tb;
  import snfd_pkg::*;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic [7:0] command;
    logic [7:0] argument;
    logic [2:0] status;
  } decode_t;

  typedef enum int {
    FLAW_NONE,
    FLAW_HEADER,
    FLAW_FOOTER,
    FLAW_CHECKSUM,
    FLAW_PARITY,
    FLAW_SHORT,
    FLAW_WIDE_LOW,
    FLAW_NOISE
  } flaw_t;

  localparam int ITEM_GOAL    = 800;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 80;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  rx_byte = 8'h00;
  logic        end_of_message = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        item_kind;
  logic [7:0]  data_byte;
  logic [7:0]  command_byte;
  logic [7:0]  argument_byte;
  logic [2:0]  status;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [47:0] header_bytes = '0;

  // frame tracking state
  logic [47:0] hdr_expected = HEADER_RESET;
  logic [3:0]  pos;
  logic        hdr_ok;
  logic        pair_odd;
  logic [3:0]  hi_nib;
  logic [7:0]  held;
  logic        held_ok;
  logic [7:0]  run_sum;
  logic [7:0]  cmd_q;
  logic [7:0]  arg_q;

  decode_t     pending_decodes[$];
  logic [7:0]  frame_bytes[$];
  int          failures = 0;
  int          items_sent = 0;
  int          hold_cycles = 0;
  bit          tx_gaps = 1'b1;
  bit          rx_stalls = 1'b1;

  sysex_nibble_frame_decoder i_dut (.*);

  always #1 clk = ~clk;

  initial begin
    #1_000_000;
    $display("sysex_nibble_frame_decoder regression: fail");
    $finish;
  end

  function automatic void clear_frame_state();
    pos      = '0;
    hdr_ok   = 1'b1;
    pair_odd = 1'b0;
    hi_nib   = '0;
    held     = '0;
    held_ok  = 1'b0;
    run_sum  = '0;
    cmd_q    = '0;
    arg_q    = '0;
  endfunction

  function automatic void expect_decode(input decode_t res);
    pending_decodes = {pending_decodes, res};
  endfunction

  function automatic void append_byte(input logic [7:0] b);
    frame_bytes = {frame_bytes, b};
  endfunction

  function automatic void decode_rx_byte(input logic [7:0] b, input logic last);
    decode_t res;
    int idx;
    res = '0;
    idx = int'(pos);
    if (last) begin
      res.kind     = KIND_STATUS;
      res.command  = cmd_q;
      res.argument = arg_q;
      if (pos < POS_MIN_LAST || pair_odd) begin
        res.status = ST_LENGTH;
      end else if (!hdr_ok) begin
        res.status = ST_HEADER;
      end else if (b != FOOTER_BYTE) begin
        res.status = ST_FOOTER;
      end else if (!held_ok || held != run_sum) begin
        res.status = ST_CHECKSUM;
      end else begin
        res.status = ST_OK;
      end
      expect_decode(res);
      clear_frame_state();
    end else begin
      if (pos < POS_COMMAND) begin
        if (b != hdr_expected[8*(5-idx) +: 8]) hdr_ok = 1'b0;
      end else if (pos == POS_COMMAND) begin
        cmd_q = b;
      end else if (pos == POS_ARGUMENT) begin
        arg_q = b;
      end else if (!pair_odd) begin
        hi_nib   = b[3:0];
        pair_odd = 1'b1;
      end else begin
        if (held_ok && hdr_ok) begin
          res.kind = KIND_DATA;
          res.data = held;
          expect_decode(res);
          run_sum = run_sum + held;
        end
        held     = {hi_nib, 4'h0} | b;
        held_ok  = 1'b1;
        pair_odd = 1'b0;
      end
      if (pos != POS_MAX) pos = pos + 4'd1;
    end
  endfunction

  function automatic void compare_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      failures++;
    end
  endfunction

  always @(posedge clk) begin
    decode_t want;
    if (!rst) begin
      if (cfg_valid && cfg_ready) hdr_expected = header_bytes;
      if (in_valid && in_ready) decode_rx_byte(rx_byte, end_of_message);
      if (out_valid && out_ready) begin
        if (pending_decodes.size() == 0) begin
          $error("unexpected result: item_kind %0d, data_byte %0h, status %0d",
                 item_kind, data_byte, status);
          failures++;
        end else begin
          want = pending_decodes.pop_front();
          compare_field("item_kind", 8'(want.kind), 8'(item_kind));
          compare_field("data_byte", want.data, data_byte);
          compare_field("command_byte", want.command, command_byte);
          compare_field("argument_byte", want.argument, argument_byte);
          compare_field("status", 8'(want.status), 8'(status));
        end
      end
    end
  end

  initial begin : receiver
    int stall;
    while (rst) @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end
      stall = rx_stalls ? $urandom_range(0, 11) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid && hold_cycles == 0);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = tx_gaps ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    rx_byte        <= b;
    end_of_message <= last;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic send_frame();
    foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
  endtask

  task automatic write_header(input logic [47:0] value);
    in_valid <= 1'b0;
    while (pending_decodes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid    <= 1'b1;
    header_bytes <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic put_header();
    for (int i = 0; i < 6; i++) append_byte(hdr_expected[8*(5-i) +: 8]);
  endtask

  task automatic push_pair(input logic [7:0] value, input logic wide);
    logic [3:0] junk;
    logic [3:0] extra;
    junk  = 4'($urandom);
    extra = (wide && $urandom_range(0, 1)) ? 4'($urandom) : 4'h0;
    append_byte({junk, value[7:4]});
    append_byte({extra, value[3:0]});
  endtask

  task automatic build_frame(input flaw_t flaw, input int pairs);
    logic [7:0] d;
    logic [7:0] chk;
    int idx;
    int len;
    frame_bytes.delete();
    if (flaw == FLAW_NOISE) begin
      len = $urandom_range(1, 30);
      repeat (len) append_byte(8'($urandom));
      return;
    end
    put_header();
    append_byte(8'($urandom));
    append_byte(8'($urandom));
    chk = '0;
    repeat (pairs) begin
      d   = 8'($urandom);
      chk = chk + d;
      push_pair(d, flaw == FLAW_WIDE_LOW);
    end
    if (flaw == FLAW_CHECKSUM) chk = chk ^ 8'(1 << $urandom_range(0, 7));
    push_pair(chk, 1'b0);
    if (flaw == FLAW_FOOTER) begin
      append_byte(FOOTER_BYTE ^ 8'($urandom_range(1, 255)));
    end else begin
      append_byte(FOOTER_BYTE);
    end
    case (flaw)
      FLAW_HEADER: begin
        idx = $urandom_range(0, 5);
        frame_bytes[idx] = frame_bytes[idx] ^ 8'($urandom_range(1, 255));
      end
      FLAW_PARITY: begin
        idx = $urandom_range(6, frame_bytes.size() - 2);
        if ($urandom_range(0, 1)) frame_bytes.delete(idx);
        else frame_bytes.insert(idx, 8'($urandom));
      end
      FLAW_SHORT: begin
        len = $urandom_range(1, 10);
        while (frame_bytes.size() > len) void'(frame_bytes.pop_back());
      end
      default: ;
    endcase
  endtask

  task automatic test_boundaries();
    send_byte(FOOTER_BYTE, 1'b1);
    frame_bytes.delete();
    put_header();
    append_byte(8'hFF);
    append_byte(8'h00);
    append_byte(8'h00);
    append_byte(8'h00);
    append_byte(FOOTER_BYTE);
    send_frame();
    frame_bytes.delete();
    put_header();
    append_byte(8'h00);
    append_byte(8'hFF);
    append_byte(8'hFF);
    append_byte(8'h0F);
    append_byte(8'h0F);
    append_byte(8'h0F);
    append_byte(8'h00);
    send_frame();
  endtask

  task automatic test_config_sweep();
    logic [63:0] r;
    logic [47:0] header_value;
    for (int k = 0; k < 5; k++) begin
      r = {$urandom, $urandom};
      case (k)
        0: header_value = '0;
        1: header_value = '1;
        4: header_value = HEADER_RESET;
        default: header_value = r[47:0];
      endcase
      write_header(header_value);
      repeat (4) begin
        build_frame($urandom_range(0, 1) ? FLAW_NONE : flaw_t'($urandom_range(1, 7)),
                    $urandom_range(0, 6));
        send_frame();
      end
    end
  endtask

  task automatic test_back_pressure();
    tx_gaps     = 1'b0;
    rx_stalls   = 1'b0;
    hold_cycles = HOLD_CYCLES;
    build_frame(FLAW_NONE, 30);
    send_frame();
    tx_gaps   = 1'b1;
    rx_stalls = 1'b1;
  endtask

  task automatic test_random_traffic();
    flaw_t flaw;
    int pairs;
    while (items_sent < ITEM_GOAL) begin
      tx_gaps   = $urandom_range(0, 3) != 0;
      rx_stalls = $urandom_range(0, 3) != 0;
      flaw  = $urandom_range(0, 1) ? FLAW_NONE : flaw_t'($urandom_range(1, 7));
      pairs = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 24) : $urandom_range(0, 6);
      build_frame(flaw, pairs);
      send_frame();
    end
  endtask

  initial begin
    clear_frame_state();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_boundaries();
    test_config_sweep();
    test_back_pressure();
    test_random_traffic();
    in_valid <= 1'b0;
    while (pending_decodes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("sysex_nibble_frame_decoder regression: pass");
    end else begin
      $display("sysex_nibble_frame_decoder regression: fail");
    end
    $finish;
  end

endmodule
